[design/xmbr_pkg.sv]
// shared types, codes and defaults for the xmodem block receiver
`default_nettype none

package xmbr_pkg;

    localparam int DATA_BYTES_DEF = 5;

    localparam logic [7:0] CODE_NAK = 8'h15;
    localparam logic [7:0] CODE_ACK = 8'h06;
    localparam logic [7:0] CODE_EOT = 8'h04;
    localparam logic [7:0] CODE_SOH = 8'h01;

    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_BYTE  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic       is_reply;
        logic [7:0] out_byte;
        logic       last;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IN,
        S_READ,
        S_EMIT,
        S_ACK
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic rd_issue;
        logic emit_payload;
        logic emit_ack;
    } t_ctrl_cmd;

    typedef struct packed {
        logic slot_free;
        logic chk_ok;
        logic rd_last;
    } t_dp_status;

endpackage

`default_nettype wire

[design/xmbr_ctrl.sv]
// controller state machine: input taking and payload release sequence
`default_nettype none

module xmbr_ctrl
    import xmbr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire t_dp_status i_status,
    output t_ctrl_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IN: begin
                if (i_in_valid && i_status.slot_free && i_status.chk_ok) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.slot_free) begin
                    n_state = i_status.rd_last ? S_ACK : S_READ;
                end
            end
            S_ACK: begin
                if (i_status.slot_free) begin
                    n_state = S_IN;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IN:    o_cmd.in_ready     = i_status.slot_free;
            S_READ:  o_cmd.rd_issue     = 1'b1;
            S_EMIT:  o_cmd.emit_payload = i_status.slot_free;
            S_ACK:   o_cmd.emit_ack     = i_status.slot_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[design/xmbr_dp.sv]
// datapath: framing counter, checksum, payload memory and output register
`default_nettype none

module xmbr_dp
    import xmbr_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_word  i_in_word,
    input  wire logic      i_out_ready,
    input  wire t_ctrl_cmd i_cmd,
    output t_dp_status     o_status,
    output logic           o_out_valid,
    output t_out_word      o_out_word
);

    localparam int POS_W = $clog2(DATA_BYTES + 4);
    localparam int IDX_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam logic [POS_W-1:0] POS_FIRST   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CHECK   = POS_W'(DATA_BYTES + 3);
    localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(DATA_BYTES - 1);

    logic             r_active;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_sum;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_rd_data;
    logic [7:0]       r_mem [DATA_BYTES];
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic             n_active;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       n_sum;
    logic             n_out_valid;
    t_out_word        n_out_word;

    logic             in_fire;
    logic             is_byte;
    logic             wr_en;
    logic [POS_W-1:0] wr_pos;
    logic [IDX_W-1:0] wr_idx;

    assign in_fire = i_in_valid && i_cmd.in_ready;
    assign is_byte = (i_in_word.action == ACTION_BYTE);
    assign wr_en   = in_fire && is_byte && r_active && (r_pos >= POS_PAYLOAD)
                     && (r_pos < POS_CHECK);
    assign wr_pos  = r_pos - POS_PAYLOAD;
    assign wr_idx  = wr_pos[IDX_W-1:0];

    assign o_status.slot_free = !r_out_valid || i_out_ready;
    assign o_status.chk_ok    = is_byte && r_active && (r_pos == POS_CHECK)
                                && (i_in_word.rx_byte == r_sum);
    assign o_status.rd_last   = (r_idx == IDX_LAST);

    // frame handling on an accepted word, and payload or ACK output during release
    always_comb begin
        n_active    = r_active;
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        if (in_fire) begin
            if (!is_byte) begin
                n_active    = 1'b1;
                n_pos       = POS_FIRST;
                n_sum       = '0;
                n_out_valid = 1'b1;
                n_out_word  = '{is_reply: 1'b1, out_byte: CODE_NAK, last: 1'b1};
            end else if (r_active) begin
                if (r_pos == POS_FIRST) begin
                    if (i_in_word.rx_byte == CODE_EOT) begin
                        n_active    = 1'b0;
                        n_out_valid = 1'b1;
                        n_out_word  = '{is_reply: 1'b1, out_byte: CODE_ACK, last: 1'b1};
                    end else if (i_in_word.rx_byte == CODE_SOH) begin
                        n_pos = r_pos + POS_W'(1);
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_word  = '{is_reply: 1'b1, out_byte: CODE_NAK, last: 1'b1};
                    end
                end else if (r_pos < POS_PAYLOAD) begin
                    // block-number bytes pass unchecked
                    n_pos = r_pos + POS_W'(1);
                end else if (r_pos < POS_CHECK) begin
                    n_sum = r_sum + i_in_word.rx_byte;
                    n_pos = r_pos + POS_W'(1);
                end else begin
                    n_pos = POS_FIRST;
                    n_sum = '0;
                    if (i_in_word.rx_byte != r_sum) begin
                        n_out_valid = 1'b1;
                        n_out_word  = '{is_reply: 1'b1, out_byte: CODE_NAK, last: 1'b1};
                    end
                end
            end
        end else if (i_cmd.emit_payload) begin
            n_out_valid = 1'b1;
            n_out_word  = '{is_reply: 1'b0, out_byte: r_rd_data, last: 1'b0};
        end else if (i_cmd.emit_ack) begin
            n_out_valid = 1'b1;
            n_out_word  = '{is_reply: 1'b1, out_byte: CODE_ACK, last: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pos       <= POS_FIRST;
            r_sum       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            if (in_fire) begin
                r_idx <= '0;
            end else if (i_cmd.emit_payload) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    // payload memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= i_in_word.rx_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

[design/xmodem_block_receiver.sv]
// top level of the xmodem block receiver with 8-bit sum check
//
//  channel | valid      | ready       | word
//  --------+------------+-------------+------------------------------------
//  input   | i_in_valid | o_in_ready  | i_in_word  (action, rx_byte)
//  output  | o_out_valid| i_out_ready | o_out_word (is_reply, out_byte, last)
//
// an input word is taken whenever the output register is free or being
// drained; a good checksum word then releases the frame, each payload byte
// read through the memory's registered read port and then emitted, followed
// by the ACK, with no input taken meanwhile.
// synchronous active-low reset clears framing and control; the payload memory
// is not cleared. a stalled output register holds input and release alike.
`default_nettype none

module xmodem_block_receiver
    import xmbr_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_word,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_word     o_out_word
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    xmbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    xmbr_dp #(
        .DATA_BYTES (DATA_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    assign o_in_ready = cmd.in_ready;

endmodule

`default_nettype wire

[tb/xmbr_frame_checker.sv]
// frame checker for the xmodem block receiver: predicts reply and payload words and compares
`timescale 1ns / 100ps

module xmbr_frame_checker
    import xmbr_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire t_in_word  i_in_word,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_word i_out_word,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int POS_PAYLOAD = 3;
    localparam int POS_CHECK   = POS_PAYLOAD + DATA_BYTES;

    logic       armed;
    int         frame_pos;
    logic [7:0] run_sum;
    logic [7:0] payload_copy [DATA_BYTES];
    t_out_word  expected_words [$];

    function automatic void queue_word(logic reply, logic [7:0] val, logic fin);
        t_out_word w;
        w.is_reply = reply;
        w.out_byte = val;
        w.last     = fin;
        expected_words.push_back(w);
    endfunction

    task automatic predict_replies(input t_in_word w);
        if (w.action == ACTION_START) begin
            armed     = 1'b1;
            frame_pos = 0;
            run_sum   = 8'h00;
            queue_word(1'b1, CODE_NAK, 1'b1);
        end else if (!armed) begin
            // byte outside a transfer is dropped
        end else if (frame_pos == 0) begin
            if (w.rx_byte == CODE_EOT) begin
                armed = 1'b0;
                queue_word(1'b1, CODE_ACK, 1'b1);
            end else if (w.rx_byte == CODE_SOH) begin
                frame_pos = 1;
            end else begin
                queue_word(1'b1, CODE_NAK, 1'b1);
            end
        end else if (frame_pos < POS_PAYLOAD) begin
            // block number bytes are not checked
            frame_pos++;
        end else if (frame_pos < POS_CHECK) begin
            payload_copy[frame_pos - POS_PAYLOAD] = w.rx_byte;
            run_sum = run_sum + w.rx_byte;
            frame_pos++;
        end else begin
            if (w.rx_byte == run_sum) begin
                for (int k = 0; k < DATA_BYTES; k++) begin
                    queue_word(1'b0, payload_copy[k], 1'b0);
                end
                queue_word(1'b1, CODE_ACK, 1'b1);
            end else begin
                queue_word(1'b1, CODE_NAK, 1'b1);
            end
            frame_pos = 0;
            run_sum   = 8'h00;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            armed     = 1'b0;
            frame_pos = 0;
            run_sum   = 8'h00;
            expected_words.delete();
        end else begin
            // output word first: it can only stem from an earlier input word
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: is_reply %0d out_byte %02h last %0d",
                           i_out_word.is_reply, i_out_word.out_byte, i_out_word.last);
                    o_fail_count++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (i_out_word.is_reply !== exp_w.is_reply) begin
                        $error("is_reply: expected %0d, got %0d",
                               exp_w.is_reply, i_out_word.is_reply);
                        o_fail_count++;
                    end
                    if (i_out_word.out_byte !== exp_w.out_byte) begin
                        $error("out_byte: expected %02h, got %02h",
                               exp_w.out_byte, i_out_word.out_byte);
                        o_fail_count++;
                    end
                    if (i_out_word.last !== exp_w.last) begin
                        $error("last: expected %0d, got %0d", exp_w.last, i_out_word.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_replies(i_in_word);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

[tb/xmodem_block_receiver_tb.sv]
// testbench top for the xmodem block receiver: stimulus, output stalls and verdict
`timescale 1ns / 100ps

module xmodem_block_receiver_tb;
    import xmbr_pkg::*;

    localparam int DATA_BYTES  = DATA_BYTES_DEF;
    localparam int ITEMS       = 410;
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 300;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    int fail_count;
    int pending;
    int sent_count = 0;
    bit no_gaps    = 1'b0;

    always #1 i_clk = ~i_clk;

    xmodem_block_receiver #(
        .DATA_BYTES(DATA_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    xmbr_frame_checker #(
        .DATA_BYTES(DATA_BYTES)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_word  (o_out_word),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // payload bytes lean toward the extremes now and then
    function automatic logic [7:0] rand_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hff;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_word(input logic act, input logic [7:0] rx);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_in_word.action  <= act;
        i_in_word.rx_byte <= rx;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
    endtask

    task automatic send_frame(input logic [7:0] data [DATA_BYTES], input bit good);
        logic [7:0] csum;
        csum = 8'h00;
        for (int k = 0; k < DATA_BYTES; k++) begin
            csum = csum + data[k];
        end
        if (!good) begin
            csum = csum ^ 8'($urandom_range(1, 255));
        end
        send_word(ACTION_BYTE, CODE_SOH);
        send_word(ACTION_BYTE, 8'($urandom_range(0, 255)));
        send_word(ACTION_BYTE, 8'($urandom_range(0, 255)));
        for (int k = 0; k < DATA_BYTES; k++) begin
            send_word(ACTION_BYTE, data[k]);
        end
        send_word(ACTION_BYTE, csum);
    endtask

    // output side stalls, plus one long hold-off to back the block up
    initial begin
        int unsigned r;
        int unsigned len;
        logic        rdy;
        bit          hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (!hold_done && sent_count >= HOLD_AFTER) begin
                hold_done = 1'b1;
                rdy = 1'b0;
                len = HOLD_CYCLES;
            end else if (r < 15) begin
                rdy = 1'b1;
                len = $urandom_range(30, 80);
            end else if (r < 60) begin
                rdy = 1'b1;
                len = $urandom_range(1, 4);
            end else if (r < 95) begin
                rdy = 1'b0;
                len = $urandom_range(1, 3);
            end else begin
                rdy = 1'b0;
                len = $urandom_range(20, 60);
            end
            i_out_ready <= rdy;
            repeat (len) @(posedge i_clk);
        end
    end

    initial begin
        #1_500_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [7:0]  data [DATA_BYTES];
        int unsigned r;
        int unsigned n;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send_word(ACTION_BYTE, 8'hff);         // nothing armed yet, dropped
        send_word(ACTION_START, 8'haa);
        data[0] = 8'h00;
        data[1] = 8'hff;
        for (int k = 2; k < DATA_BYTES; k++) begin
            data[k] = 8'(8'h80 - k + 2);
        end
        send_frame(data, 1'b1);
        for (int k = 0; k < DATA_BYTES; k++) begin
            data[k] = 8'($urandom_range(0, 255));
        end
        send_frame(data, 1'b0);
        send_word(ACTION_BYTE, 8'h55);         // junk at frame start
        send_word(ACTION_BYTE, CODE_SOH);
        send_word(ACTION_BYTE, 8'h12);
        send_word(ACTION_START, 8'h55);        // restart in the middle of a frame
        send_word(ACTION_BYTE, CODE_EOT);
        send_word(ACTION_BYTE, CODE_SOH);      // transfer over, dropped
        send_word(ACTION_START, 8'h00);

        // random part: mostly clean frames, some noise and broken frames
        while (sent_count < ITEMS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                for (int k = 0; k < DATA_BYTES; k++) begin
                    data[k] = rand_byte();
                end
                send_frame(data, $urandom_range(0, 4) != 0);
            end else if (r < 80) begin
                send_word(ACTION_BYTE, 8'($urandom_range(0, 255)));
            end else if (r < 87) begin
                // frame cut short, then resync with a start
                send_word(ACTION_BYTE, CODE_SOH);
                n = $urandom_range(1, DATA_BYTES + 1);
                repeat (n) send_word(ACTION_BYTE, rand_byte());
                send_word(ACTION_START, 8'($urandom_range(0, 255)));
            end else if (r < 93) begin
                send_word(ACTION_START, 8'($urandom_range(0, 255)));
            end else begin
                send_word(ACTION_BYTE, CODE_EOT);
                n = $urandom_range(0, 2);
                repeat (n) send_word(ACTION_BYTE, 8'($urandom_range(0, 255)));
                send_word(ACTION_START, 8'($urandom_range(0, 255)));
            end
        end
        no_gaps = 1'b0;
        i_in_valid <= 1'b0;

        wait (pending == 0);
        repeat (4 * DATA_BYTES + 8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
